>>> rtl/rgbed_pkg.sv
// shared constants, types and arithmetic helpers for the rgb888 to rgb555
// error diffusion core; no dependencies
`default_nettype none

package rgbed_pkg;

  // row store depth default
  localparam int MAX_WIDTH_DFLT = 1024;

  // line width register
  localparam int                LW_W     = 11;
  localparam logic [LW_W-1:0]   LW_RESET = 11'd1024;
  localparam int                APB_DW   = 32;
  localparam int                APB_AW   = 2;
  localparam logic [APB_AW-1:0] ADDR_LINE_WIDTH = 2'd0;

  // color channels: red, green, blue
  localparam int NCH   = 3;
  localparam int PIX_W = 8;
  localparam int Q_W   = 5;

  // diffused errors stay within -3..3, residual within -7..7
  localparam int ERR_W = 4;

  // reconstruction q*255/31 = 8q + floor(7q/31), the second term by reciprocal
  localparam int PIX_MAX    = 255;
  localparam int Q_MAX      = 31;
  localparam int RECON_FRAC = PIX_MAX - Q_MAX * 8;
  localparam int RECIP_SH   = 13;
  localparam int RECIP      = (2 ** RECIP_SH + Q_MAX - 1) / Q_MAX;

  // diffusion weights, sixteenths
  localparam logic [2:0] W_RIGHT  = 3'd7;
  localparam logic [2:0] W_DLEFT  = 3'd3;
  localparam logic [2:0] W_DOWN   = 3'd5;
  localparam logic [2:0] W_DRIGHT = 3'd1;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [Q_W-1:0]          q_t;

  // e * w / 16, truncated toward zero
  function automatic err_t share(input err_t e, input logic [2:0] wgt);
    logic signed [7:0] p;
    p = e * $signed({1'b0, wgt});
    if (p < 0) begin
      p = p + 8'sd15;
    end
    return err_t'(p >>> 4);
  endfunction

  // q * 255 / 31
  function automatic pix_t recon(input q_t q);
    logic [15:0] t;
    t = 16'(q) * 16'(RECON_FRAC) * 16'(RECIP);
    return pix_t'({q, 3'b000}) + pix_t'(t >> RECIP_SH);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rgb888_to_rgb555_error_diffusion_core.sv
// rgb888 to rgb555 conversion with floyd-steinberg error diffusion
// out_valid follows word accept through the work stage register and then the result register
// throughput: one word per cycle unless out_stall holds the pipe; one row store read and at most one write per word
// reset: synchronous, active low; clears control state and the line width (1024)
// the row store needs no clearing pass: a fill count marks valid columns per frame
// depends on rgbed_pkg
`default_nettype none

module rgb888_to_rgb555_error_diffusion_core #(
  parameter int MAX_WIDTH = rgbed_pkg::MAX_WIDTH_DFLT
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // pixel input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_frame_start,
  input  wire  [rgbed_pkg::PIX_W-1:0]       in_red_in,
  input  wire  [rgbed_pkg::PIX_W-1:0]       in_green_in,
  input  wire  [rgbed_pkg::PIX_W-1:0]       in_blue_in,
  // packed pixel output channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [14:0]                       out_rgb555,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [rgbed_pkg::APB_AW-1:0]      paddr,
  input  wire  [rgbed_pkg::APB_DW-1:0]      pwdata,
  output logic [rgbed_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column index
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);                    // widths and counts
  localparam int WORD_W = rgbed_pkg::NCH * rgbed_pkg::ERR_W;        // one row store entry
  localparam int NCH    = rgbed_pkg::NCH;
  localparam int ERR_W  = rgbed_pkg::ERR_W;

  // ---------------------------------------------------------------------------
  // configuration: line width register, reads return it at its address
  // ---------------------------------------------------------------------------
  logic [rgbed_pkg::LW_W-1:0] lw_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == rgbed_pkg::ADDR_LINE_WIDTH);

  always_comb begin
    if (paddr == rgbed_pkg::ADDR_LINE_WIDTH) begin
      prdata = rgbed_pkg::APB_DW'(lw_r);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= rgbed_pkg::LW_RESET;
    end else if (cfg_wr) begin
      lw_r <= pwdata[rgbed_pkg::LW_W-1:0];
    end
  end

  // effective width: zero acts as one, anything past the store depth is capped
  logic [CNT_W-1:0] w_eff;

  always_comb begin
    if (lw_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(lw_r) > 32'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(lw_r);
    end
  end

  // ---------------------------------------------------------------------------
  // accept side: column tracking does not depend on pixel data, so the
  // column and the fill count advance right at accept and the row store
  // read for the column is issued in the same edge
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic [COL_W-1:0] col_acc_r, col_acc_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [COL_W-1:0] col_start, c_acc;
  logic [CNT_W-1:0] c_acc_ext, fill_eff;
  logic             hr_acc;
  logic             rdok_acc;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    col_start = in_frame_start ? '0 : col_acc_r;
    // width shrunk under a running row: restart the row
    c_acc     = (CNT_W'(col_start) >= w_eff) ? '0 : col_start;
    c_acc_ext = CNT_W'(c_acc);
    hr_acc    = (c_acc_ext + CNT_W'(1)) < w_eff;
    col_acc_nxt = hr_acc ? COL_W'(c_acc_ext + CNT_W'(1)) : '0;
    // columns below the fill count were stored during this frame
    fill_eff  = in_frame_start ? '0 : fill_r;
    rdok_acc  = c_acc_ext < fill_eff;
    fill_nxt  = ((c_acc_ext + CNT_W'(1)) > fill_eff) ? (c_acc_ext + CNT_W'(1)) : fill_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_acc_r <= '0;
      fill_r    <= '0;
    end else if (in_acc) begin
      col_acc_r <= col_acc_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // row store: one write port from the work stage, one registered read at accept
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic              mem_we;
  logic [COL_W-1:0]  mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic [WORD_W-1:0] s1_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      s1_rd_r <= mem[c_acc];
    end
  end

  // ---------------------------------------------------------------------------
  // work stage register
  // ---------------------------------------------------------------------------
  logic                        s1_vld_r;
  logic                        s1_fs_r;
  logic [COL_W-1:0]            s1_c_r;
  logic                        s1_hr_r;
  logic                        s1_rdok_r;
  logic                        s1_byp_r;      // same-edge write forwarded past the read
  logic [WORD_W-1:0]           s1_bypd_r;
  rgbed_pkg::pix_t             s1_pix_r [NCH];
  logic                        s1_adv;
  logic                        out_vld_r;

  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fs_r     <= in_frame_start;
      s1_c_r      <= c_acc;
      s1_hr_r     <= hr_acc;
      s1_rdok_r   <= rdok_acc;
      s1_byp_r    <= mem_we && (mem_wa == c_acc);
      s1_bypd_r   <= mem_wd;
      s1_pix_r[0] <= in_red_in;
      s1_pix_r[1] <= in_green_in;
      s1_pix_r[2] <= in_blue_in;
    end
  end

  // ---------------------------------------------------------------------------
  // diffusion state: right and down-right shares, plus the entry of the
  // last column, held back until its down-left share is known
  // ---------------------------------------------------------------------------
  rgbed_pkg::err_t  right_r [NCH];
  rgbed_pkg::err_t  bc_r    [NCH];
  rgbed_pkg::err_t  pend_r  [NCH];
  logic [COL_W-1:0] pend_col_r;
  logic             pend_vld_r;

  rgbed_pkg::err_t  right_nxt [NCH];
  rgbed_pkg::err_t  bc_nxt    [NCH];
  rgbed_pkg::err_t  pend_nxt  [NCH];
  rgbed_pkg::err_t  dl_wr     [NCH];   // finished entry of the previous column

  logic             pend_live, pend_hit, c_zero;
  logic [WORD_W-1:0] store_word;
  rgbed_pkg::err_t  nb   [NCH];
  rgbed_pkg::err_t  rgt  [NCH];
  rgbed_pkg::err_t  bcu  [NCH];
  logic signed [9:0] v   [NCH];
  rgbed_pkg::pix_t  vc   [NCH];
  rgbed_pkg::q_t    q    [NCH];
  logic signed [9:0] e10 [NCH];
  rgbed_pkg::err_t  e    [NCH];

  always_comb begin
    // frame start drops the held entry along with the row store
    pend_live  = pend_vld_r && !s1_fs_r;
    pend_hit   = pend_live && (pend_col_r == s1_c_r);
    c_zero     = (s1_c_r == '0);
    store_word = s1_byp_r ? s1_bypd_r : s1_rd_r;

    for (int ch = 0; ch < NCH; ch++) begin
      // error from the row above
      if (pend_hit) begin
        nb[ch] = pend_r[ch];
      end else if (s1_rdok_r) begin
        nb[ch] = rgbed_pkg::err_t'(store_word[ch*ERR_W +: ERR_W]);
      end else begin
        nb[ch] = '0;
      end
      // row start sees no carried error
      rgt[ch] = c_zero ? rgbed_pkg::err_t'(0) : right_r[ch];
      bcu[ch] = c_zero ? rgbed_pkg::err_t'(0) : bc_r[ch];

      v[ch] = $signed({2'b00, s1_pix_r[ch]}) + rgt[ch] + nb[ch];
      if (v[ch] < 0) begin
        vc[ch] = '0;
      end else if (v[ch] > 10'sd255) begin
        vc[ch] = '1;
      end else begin
        vc[ch] = v[ch][7:0];
      end
      q[ch]   = vc[ch][7:3];
      e10[ch] = $signed({2'b00, vc[ch]}) - $signed({2'b00, rgbed_pkg::recon(q[ch])});
      e[ch]   = rgbed_pkg::err_t'(e10[ch]);

      pend_nxt[ch]  = bcu[ch] + rgbed_pkg::share(e[ch], rgbed_pkg::W_DOWN);
      dl_wr[ch]     = pend_r[ch] + rgbed_pkg::share(e[ch], rgbed_pkg::W_DLEFT);
      right_nxt[ch] = s1_hr_r ? rgbed_pkg::share(e[ch], rgbed_pkg::W_RIGHT)
                              : rgbed_pkg::err_t'(0);
      bc_nxt[ch]    = s1_hr_r ? rgbed_pkg::share(e[ch], rgbed_pkg::W_DRIGHT)
                              : rgbed_pkg::err_t'(0);
    end

    // mid row: previous column is now final; row start: flush the held entry
    mem_we = s1_adv && (!c_zero || pend_live);
    mem_wa = c_zero ? pend_col_r : (s1_c_r - COL_W'(1));
    for (int ch = 0; ch < NCH; ch++) begin
      mem_wd[ch*ERR_W +: ERR_W] = c_zero ? pend_r[ch] : dl_wr[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      for (int ch = 0; ch < NCH; ch++) begin
        right_r[ch] <= '0;
        bc_r[ch]    <= '0;
      end
    end else if (s1_adv) begin
      pend_vld_r <= 1'b1;
      for (int ch = 0; ch < NCH; ch++) begin
        right_r[ch] <= right_nxt[ch];
        bc_r[ch]    <= bc_nxt[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pend_col_r <= s1_c_r;
      for (int ch = 0; ch < NCH; ch++) begin
        pend_r[ch] <= pend_nxt[ch];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register: takes a word while the previous one leaves
  // ---------------------------------------------------------------------------
  logic [14:0] out_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rgb_r <= {q[0], q[1], q[2]};
    end
  end

  assign out_valid  = out_vld_r;
  assign out_rgb555 = out_rgb_r;

endmodule

`default_nettype wire

>>> tb/tb_rgb888_to_rgb555_error_diffusion_core.sv
// testbench for the rgb888 to rgb555 error diffusion core: directed and random pixel
// streams checked word by word against an in-bench error diffusion predictor
// depends on rgbed_pkg and rgb888_to_rgb555_error_diffusion_core
`timescale 1ns / 100ps

module tb_rgb888_to_rgb555_error_diffusion_core;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ROW_DEPTH    = rgbed_pkg::MAX_WIDTH_DFLT;
  localparam int LW_W         = rgbed_pkg::LW_W;
  localparam int APB_AW       = rgbed_pkg::APB_AW;
  localparam int APB_DW       = rgbed_pkg::APB_DW;
  localparam int Q_W          = rgbed_pkg::Q_W;
  localparam int WIDE_RUN     = 60;
  localparam int RANDOM_WORDS = 820;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_frame_start = 1'b0;
  rgbed_pkg::pix_t      in_red_in = '0;
  rgbed_pkg::pix_t      in_green_in = '0;
  rgbed_pkg::pix_t      in_blue_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [14:0]          out_rgb555;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // random idling on both channels, switched off for the long clean stretch
  bit                   idle_on = 1'b1;
  int                   fail_cnt = 0;
  int                   cycle_cnt = 0;

  // expected packed pixels, oldest first
  logic [14:0]          pix_expect[$];

  // predictor state: next row errors per column and channel, right and
  // down-right carries, current column and the line width shadow
  int                   row_err[ROW_DEPTH][3];
  int                   right_err[3];
  int                   diag_err[3];
  int                   pix_col = 0;
  logic [LW_W-1:0]      lw_shadow = rgbed_pkg::LW_RESET;

  rgb888_to_rgb555_error_diffusion_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_start (in_frame_start),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rgb555     (out_rgb555),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, reckoned from the slowest correct run several times over
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("rgb888_to_rgb555_error_diffusion_core verification failed");
      $finish;
    end
  end

  // zero widths act as one, anything past the row store depth acts as the depth
  function automatic int eff_width();
    if (lw_shadow == 0) return 1;
    if (lw_shadow > ROW_DEPTH) return ROW_DEPTH;
    return int'(lw_shadow);
  endfunction

  // predicts the packed pixel for one accepted word and advances the state
  function automatic logic [14:0] dither_pixel(input logic fs, input rgbed_pkg::pix_t r,
                                               input rgbed_pkg::pix_t g,
                                               input rgbed_pkg::pix_t b);
    int   w;
    int   c;
    int   v;
    int   q;
    int   rc;
    int   e;
    bit   has_right;
    rgbed_pkg::pix_t px[3];
    logic [Q_W-1:0] qv[3];
    px[0] = r;
    px[1] = g;
    px[2] = b;
    w = eff_width();
    // frame start wipes every stored error before the pixel is used
    if (fs) begin
      foreach (row_err[i, j]) row_err[i][j] = 0;
      right_err = '{0, 0, 0};
      diag_err  = '{0, 0, 0};
      pix_col   = 0;
    end
    // width shrunk under the current column: open a new row
    if (pix_col >= w) begin
      right_err = '{0, 0, 0};
      diag_err  = '{0, 0, 0};
      pix_col   = 0;
    end
    c = pix_col;
    has_right = (c + 1) < w;
    for (int ch = 0; ch < 3; ch++) begin
      v = int'(px[ch]) + right_err[ch] + row_err[c][ch];
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      q  = v / 8;
      rc = q * 255 / 31;
      e  = v - rc;
      qv[ch] = q[Q_W-1:0];
      // shares truncate toward zero, as int division does
      row_err[c][ch] = diag_err[ch] + e * 5 / 16;
      if (c > 0) row_err[c-1][ch] += e * 3 / 16;
      diag_err[ch]  = has_right ? e / 16 : 0;
      right_err[ch] = has_right ? e * 7 / 16 : 0;
    end
    // last column of the row drops its right and down-right shares
    if (has_right) begin
      pix_col = c + 1;
    end else begin
      pix_col   = 0;
      right_err = '{0, 0, 0};
      diag_err  = '{0, 0, 0};
    end
    return {qv[0], qv[1], qv[2]};
  endfunction

  // result side: compare every accepted word, then choose the next stall
  always @(posedge clk) begin
    logic [14:0] exp_pix;
    if (rst_n && out_valid && !out_stall) begin
      if (pix_expect.size() == 0) begin
        $error("rgb555 word with none expected: actual %h", out_rgb555);
        fail_cnt++;
      end else begin
        exp_pix = pix_expect.pop_front();
        if (out_rgb555 !== exp_pix) begin
          $error("rgb555 mismatch: expected %h, actual %h", exp_pix, out_rgb555);
          fail_cnt++;
        end
      end
    end
    out_stall <= idle_on && ($urandom_range(99) < 18);
  end

  // offer one pixel word, hold it until accepted, then record its prediction
  task automatic send_pixel(input logic fs, input rgbed_pkg::pix_t r,
                            input rgbed_pkg::pix_t g, input rgbed_pkg::pix_t b);
    if (idle_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid       <= 1'b1;
    in_frame_start <= fs;
    in_red_in      <= r;
    in_green_in    <= g;
    in_blue_in     <= b;
    do @(posedge clk); while (in_stall);
    pix_expect.push_back(dither_pixel(fs, r, g, b));
  endtask

  // line width write with read back, only once every pending word has come out
  task automatic write_line_width(input logic [LW_W-1:0] width);
    in_valid <= 1'b0;
    while (pix_expect.size() != 0) @(posedge clk);
    // setup then access phase of the write
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= rgbed_pkg::ADDR_LINE_WIDTH;
    pwdata  <= APB_DW'(width);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lw_shadow = width;
    // read back the same register
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LW_W-1:0] !== width) begin
      $error("line_width readback mismatch: expected %0d, actual %0d", width,
             prdata[LW_W-1:0]);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly random, often the frame's base color, sometimes a rail value
  function automatic rgbed_pkg::pix_t chan_level(input rgbed_pkg::pix_t base);
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return rgbed_pkg::pix_t'($urandom_range(255));
    if (pick < 78) return base;
    if (pick < 90) return rgbed_pkg::pix_t'(base + $urandom_range(7));
    return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
  endfunction

  // default width straight out of reset, store untouched, no frame start;
  // rail values plus a value at the foot of the top bin that leaves a negative error
  task automatic test_reset_state();
    send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd248, 8'd248, 8'd248);
    send_pixel(1'b0, 8'd0, 8'd255, 8'd7);
  endtask

  // zero width behaves as one column, then an explicit one column row
  task automatic test_narrow_widths();
    write_line_width(11'd0);
    send_pixel(1'b1, 8'd255, 8'd4, 8'd0);
    send_pixel(1'b0, 8'd255, 8'd4, 8'd0);
    send_pixel(1'b0, 8'd3, 8'd252, 8'd255);
    write_line_width(11'd1);
    send_pixel(1'b1, 8'd250, 8'd5, 8'd128);
    send_pixel(1'b0, 8'd250, 8'd5, 8'd128);
  endtask

  // three rows of three: every row hits both its row edges and the down-left share
  task automatic test_row_edges();
    write_line_width(11'd3);
    for (int i = 0; i < 9; i++) begin
      send_pixel(i == 0, (i % 2 != 0) ? 8'd255 : 8'd0, (i % 3 == 0) ? 8'd255 : 8'd4,
                 8'd248);
    end
  endtask

  // width drops below the current column while a row is open
  task automatic test_width_change_mid_row();
    write_line_width(11'd8);
    send_pixel(1'b1, 8'd100, 8'd200, 8'd13);
    send_pixel(1'b0, 8'd101, 8'd201, 8'd14);
    send_pixel(1'b0, 8'd102, 8'd202, 8'd15);
    write_line_width(11'd2);
    send_pixel(1'b0, 8'd103, 8'd203, 8'd16);
    send_pixel(1'b0, 8'd104, 8'd204, 8'd17);
  endtask

  // oversize width clamps to the store depth, then the reset width again
  // mid row; no idling for this stretch
  task automatic test_widest_row();
    idle_on = 1'b0;
    write_line_width(11'd2047);
    send_pixel(1'b1, rgbed_pkg::pix_t'($urandom_range(255)),
               rgbed_pkg::pix_t'($urandom_range(255)),
               rgbed_pkg::pix_t'($urandom_range(255)));
    for (int i = 1; i < WIDE_RUN; i++) begin
      send_pixel(1'b0, rgbed_pkg::pix_t'($urandom_range(255)),
                 rgbed_pkg::pix_t'($urandom_range(255)),
                 rgbed_pkg::pix_t'($urandom_range(255)));
    end
    write_line_width(rgbed_pkg::LW_RESET);
    for (int i = 0; i < 4; i++) begin
      send_pixel(1'b0, 8'd255, 8'd0, rgbed_pkg::pix_t'($urandom_range(255)));
    end
    idle_on = 1'b1;
  endtask

  // random frames of mostly narrow widths; a few frames skip their frame
  // start or get a stray one part way through
  task automatic test_random_frames();
    int   words;
    int   w_pick;
    int   total;
    int   fs_at;
    bit   skip_fs;
    rgbed_pkg::pix_t base_r;
    rgbed_pkg::pix_t base_g;
    rgbed_pkg::pix_t base_b;
    words = 0;
    while (words < RANDOM_WORDS) begin
      if (words == 0 || $urandom_range(99) < 60) begin
        w_pick = $urandom_range(99);
        if (w_pick < 65) write_line_width(LW_W'($urandom_range(12, 1)));
        else if (w_pick < 88) write_line_width(LW_W'($urandom_range(48, 13)));
        else if (w_pick < 93) write_line_width('0);
        else write_line_width(LW_W'($urandom_range(96, 49)));
      end
      total   = eff_width() * $urandom_range(5, 1) + $urandom_range(eff_width() - 1, 0);
      // the last frame stops at the word budget
      if (total > RANDOM_WORDS - words) total = RANDOM_WORDS - words;
      skip_fs = $urandom_range(99) < 8;
      fs_at   = ($urandom_range(99) < 6) ? $urandom_range(total, 1) : -1;
      base_r  = rgbed_pkg::pix_t'($urandom_range(255));
      base_g  = rgbed_pkg::pix_t'($urandom_range(255));
      base_b  = rgbed_pkg::pix_t'($urandom_range(255));
      for (int i = 0; i < total; i++) begin
        send_pixel((i == 0 && !skip_fs) || i == fs_at, chan_level(base_r),
                   chan_level(base_g), chan_level(base_b));
        words++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_narrow_widths();
    test_row_edges();
    test_width_change_mid_row();
    test_widest_row();
    test_random_frames();
    // drain, then give the two-stage pipe room to show any stray word
    in_valid <= 1'b0;
    while (pix_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("rgb888_to_rgb555_error_diffusion_core verification clean");
    end else begin
      $display("rgb888_to_rgb555_error_diffusion_core verification failed");
    end
    $finish;
  end

endmodule
